/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the lock manager checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RWL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwl assertion failed");

// next-cycle implication
`define RWL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwl assertion failed");

`endif

/* design/rwl_pkg.sv */
// ---------------------------------------------------------------------------
// rwl_pkg
// shared types, codes and defaults of the reader-writer lock manager
// ---------------------------------------------------------------------------
`default_nettype none

package rwl_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int FUNC_W   = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;
	localparam int HOLD_W   = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOCK_SH = 2'd0,
		FUNC_LOCK_EX = 2'd1,
		FUNC_TRY_EX  = 2'd2,
		FUNC_UNLOCK  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED     = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_TRY_REFUSED = 3'd2,
		ST_QUEUE_FULL  = 3'd3,
		ST_RELEASED    = 3'd4,
		ST_REL_ERROR   = 3'd5,
		ST_OVERFLOW    = 3'd6
	} status_t;

	typedef enum logic {
		KIND_REPLY = 1'b0,
		KIND_WAKE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic pop;
		logic enq;
		logic enq_excl;
	} q_ctl_t;

endpackage

`default_nettype wire

/* design/rwl_req_if.sv */
// ---------------------------------------------------------------------------
// rwl_req_if
// request channel of the lock manager: operation and requester id
// ---------------------------------------------------------------------------
`default_nettype none

interface rwl_req_if import rwl_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   requester_id;

	modport source (output valid, output func, output requester_id, input ready);
	modport sink   (input valid, input func, input requester_id, output ready);

endinterface

`default_nettype wire

/* design/rwl_rsp_if.sv */
// ---------------------------------------------------------------------------
// rwl_rsp_if
// result channel of the lock manager: replies and wake grants
// ---------------------------------------------------------------------------
`default_nettype none

interface rwl_rsp_if import rwl_pkg::*; ();

	logic                valid;
	logic                ready;
	logic                reply_kind;
	logic [ID_W-1:0]     target_id;
	logic [STATUS_W-1:0] status;
	logic                exclusive_held;
	logic                requester_owns;
	logic [HOLD_W-1:0]   hold_count;
	logic                last;

	modport source (
		output valid, output reply_kind, output target_id, output status,
		output exclusive_held, output requester_owns, output hold_count,
		output last, input ready
	);
	modport sink (
		input valid, input reply_kind, input target_id, input status,
		input exclusive_held, input requester_owns, input hold_count,
		input last, output ready
	);

endinterface

`default_nettype wire

/* design/rwl_cell.sv */
// ---------------------------------------------------------------------------
// rwl_cell
// one waiter slot: id, exclusive flag and length of the shared run behind it
// ---------------------------------------------------------------------------
`default_nettype none

module rwl_cell import rwl_pkg::*; #(
	parameter int ID_BITS  = ID_BITS_DEF,
	parameter int RUN_BITS = 5
) (
	input  logic                clk,
	input  q_ctl_t              ctl,
	input  logic                live,
	input  logic                at_tail,
	input  logic [ID_BITS-1:0]  enq_id,
	input  logic                nxt_excl,
	input  logic [ID_BITS-1:0]  nxt_id,
	input  logic [RUN_BITS-1:0] nxt_run,
	input  logic                nxt_reach,
	output logic                excl,
	output logic [ID_BITS-1:0]  id,
	output logic [RUN_BITS-1:0] run,
	output logic                reach
);

	logic                excl_q;
	logic [ID_BITS-1:0]  id_q;
	logic [RUN_BITS-1:0] run_q;
	logic                reach_q;

	// run_q: shared waiters starting here, reach_q: that run extends to the tail
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			excl_q  <= nxt_excl;
			id_q    <= nxt_id;
			run_q   <= nxt_run;
			reach_q <= nxt_reach;
		end else if (ctl.enq) begin
			if (at_tail) begin
				excl_q  <= ctl.enq_excl;
				id_q    <= enq_id;
				run_q   <= ctl.enq_excl ? '0 : RUN_BITS'(1);
				reach_q <= !ctl.enq_excl;
			end else if (live) begin
				if (ctl.enq_excl) begin
					reach_q <= 1'b0;
				end else if (reach_q) begin
					run_q <= run_q + RUN_BITS'(1);
				end
			end
		end
	end

	assign excl  = excl_q;
	assign id    = id_q;
	assign run   = run_q;
	assign reach = reach_q;

endmodule

`default_nettype wire

/* design/rwl_chain.sv */
// ---------------------------------------------------------------------------
// rwl_chain
// waiter queue as a row of cells shifting toward the head on each pop
// ---------------------------------------------------------------------------
`default_nettype none

module rwl_chain import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  q_ctl_t                                ctl,
	input  logic [ID_BITS-1:0]                    enq_id,
	output logic                                  head_excl,
	output logic [ID_BITS-1:0]                    head_id,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0]    head_run,
	output logic                                  empty,
	output logic                                  full
);

	localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [OCC_BITS-1:0] occ_q;

	logic                excl_w  [QUEUE_DEPTH];
	logic [ID_BITS-1:0]  id_w    [QUEUE_DEPTH];
	logic [OCC_BITS-1:0] run_w   [QUEUE_DEPTH];
	logic                reach_w [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                nx_excl;
		logic [ID_BITS-1:0]  nx_id;
		logic [OCC_BITS-1:0] nx_run;
		logic                nx_reach;

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign nx_excl  = 1'b0;
			assign nx_id    = '0;
			assign nx_run   = '0;
			assign nx_reach = 1'b0;
		end else begin : g_mid
			assign nx_excl  = excl_w[i+1];
			assign nx_id    = id_w[i+1];
			assign nx_run   = run_w[i+1];
			assign nx_reach = reach_w[i+1];
		end

		rwl_cell #(
			.ID_BITS  (ID_BITS),
			.RUN_BITS (OCC_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.live      (OCC_BITS'(i) < occ_q),
			.at_tail   (occ_q == OCC_BITS'(i)),
			.enq_id    (enq_id),
			.nxt_excl  (nx_excl),
			.nxt_id    (nx_id),
			.nxt_run   (nx_run),
			.nxt_reach (nx_reach),
			.excl      (excl_w[i]),
			.id        (id_w[i]),
			.run       (run_w[i]),
			.reach     (reach_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.pop) begin
			occ_q <= occ_q - OCC_BITS'(1);
		end else if (ctl.enq) begin
			occ_q <= occ_q + OCC_BITS'(1);
		end
	end

	assign head_excl = excl_w[0];
	assign head_id   = id_w[0];
	assign head_run  = run_w[0];
	assign empty     = (occ_q == '0);
	assign full      = (occ_q == OCC_BITS'(QUEUE_DEPTH));

endmodule

`default_nettype wire

/* design/reader_writer_lock_manager_top.sv */
// ---------------------------------------------------------------------------
// reader_writer_lock_manager_top
// reader-writer lock with recursive exclusive owner and a queue of waiters
// ---------------------------------------------------------------------------
// A request is taken and its reply, which already shows the hold count and
// owner as they stand after the whole step, is registered as it is taken;
// the next request is taken as soon as the reply register is free or being
// emptied. An unlock that drops the count to zero with waiters queued is
// followed by its wake grants, one per cycle while the result side takes
// them, each pop shifting the cell row of the waiter queue one place toward
// the head; no new request is taken until the last of its N wake grants is
// registered (N is 1 for an exclusive waiter, else the run of shared
// waiters at the head, capped at the maximum count).
// There is no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module reader_writer_lock_manager_top import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rwl_req_if.sink    req,
	rwl_rsp_if.source  rsp
);

	localparam int RUN_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_BITS = (RUN_BITS > COUNT_BITS) ? RUN_BITS : COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic {
		S_IDLE,
		S_WAKE
	} state_t;

	state_t              state_q;
	logic [COUNT_BITS-1:0] holds_q;
	logic                owner_valid_q;
	logic [ID_BITS-1:0]  owner_id_q;
	logic [RUN_BITS-1:0] wake_left_q;

	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [ID_BITS-1:0]  out_target_q;
	status_t             out_status_q;
	logic                out_excl_q;
	logic                out_owns_q;
	logic [COUNT_BITS-1:0] out_holds_q;
	logic                out_last_q;

	q_ctl_t              q_ctl;
	logic                head_excl;
	logic [ID_BITS-1:0]  head_id;
	logic [RUN_BITS-1:0] head_run;
	logic                q_empty;
	logic                q_full;

	logic                out_free;
	logic                accept;
	func_t               func;
	logic [ID_BITS-1:0]  req_id;
	logic                req_owns;
	logic                holds_zero;
	logic                holds_max;
	logic [RUN_BITS-1:0] run_capped;

	logic [COUNT_BITS-1:0] holds_d;
	logic                owner_valid_d;
	logic [ID_BITS-1:0]  owner_id_d;
	status_t             status_d;
	logic                enq_d;
	logic                enq_excl_d;
	logic [RUN_BITS-1:0] wake_n;
	logic                owns_d;

	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE) && out_free;
	assign accept     = req.valid && req.ready;
	assign func       = func_t'(req.func);
	assign req_id     = ID_BITS'(req.requester_id);
	assign req_owns   = owner_valid_q && (owner_id_q == req_id);
	assign holds_zero = (holds_q == '0);
	assign holds_max  = (holds_q == COUNT_MAX);
	assign run_capped = (CMP_BITS'(head_run) > CMP_BITS'(COUNT_MAX)) ?
		RUN_BITS'(COUNT_MAX) : head_run;

	always_comb begin
		holds_d       = holds_q;
		owner_valid_d = owner_valid_q;
		owner_id_d    = owner_id_q;
		status_d      = ST_GRANTED;
		enq_d         = 1'b0;
		enq_excl_d    = 1'b0;
		wake_n        = '0;
		unique case (func)
			FUNC_LOCK_SH: begin
				if (!holds_zero && owner_valid_q && !req_owns) begin
					if (q_full) begin
						status_d = ST_QUEUE_FULL;
					end else begin
						status_d = ST_QUEUED;
						enq_d    = 1'b1;
					end
				end else if (holds_max) begin
					status_d = ST_OVERFLOW;
				end else begin
					holds_d = holds_q + COUNT_BITS'(1);
				end
			end
			FUNC_LOCK_EX, FUNC_TRY_EX: begin
				if (!holds_zero && !req_owns) begin
					if (func == FUNC_TRY_EX) begin
						status_d = ST_TRY_REFUSED;
					end else if (q_full) begin
						status_d = ST_QUEUE_FULL;
					end else begin
						status_d   = ST_QUEUED;
						enq_d      = 1'b1;
						enq_excl_d = 1'b1;
					end
				end else if (holds_max) begin
					status_d = ST_OVERFLOW;
				end else begin
					holds_d       = holds_q + COUNT_BITS'(1);
					owner_valid_d = 1'b1;
					owner_id_d    = req_id;
				end
			end
			FUNC_UNLOCK: begin
				if (holds_zero) begin
					status_d = ST_REL_ERROR;
				end else begin
					status_d = ST_RELEASED;
					holds_d  = holds_q - COUNT_BITS'(1);
					if (holds_q == COUNT_BITS'(1)) begin
						if (q_empty) begin
							owner_valid_d = 1'b0;
						end else if (head_excl) begin
							holds_d       = COUNT_BITS'(1);
							owner_valid_d = 1'b1;
							owner_id_d    = head_id;
							wake_n        = RUN_BITS'(1);
						end else begin
							holds_d       = COUNT_BITS'(run_capped);
							owner_valid_d = 1'b0;
							owner_id_d    = '0;
							wake_n        = run_capped;
						end
					end
				end
			end
		endcase
	end

	assign owns_d = owner_valid_d && (owner_id_d == req_id);

	assign q_ctl.pop      = (state_q == S_WAKE) && out_free;
	assign q_ctl.enq      = accept && enq_d;
	assign q_ctl.enq_excl = enq_excl_d;

	rwl_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.enq_id    (req_id),
		.head_excl (head_excl),
		.head_id   (head_id),
		.head_run  (head_run),
		.empty     (q_empty),
		.full      (q_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			holds_q       <= '0;
			owner_valid_q <= 1'b0;
			owner_id_q    <= '0;
			wake_left_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						holds_q       <= holds_d;
						owner_valid_q <= owner_valid_d;
						owner_id_q    <= owner_id_d;
						wake_left_q   <= wake_n;
						out_valid_q   <= 1'b1;
						out_kind_q    <= KIND_REPLY;
						out_target_q  <= req_id;
						out_status_q  <= status_d;
						out_excl_q    <= owner_valid_d;
						out_owns_q    <= owns_d;
						out_holds_q   <= holds_d;
						out_last_q    <= (wake_n == '0);
						if (wake_n != '0) begin
							state_q <= S_WAKE;
						end
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_WAKE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_WAKE;
						out_target_q <= head_id;
						out_status_q <= ST_GRANTED;
						out_excl_q   <= owner_valid_q;
						out_owns_q   <= owner_valid_q && (owner_id_q == head_id);
						out_holds_q  <= holds_q;
						out_last_q   <= (wake_left_q == RUN_BITS'(1));
						wake_left_q  <= wake_left_q - RUN_BITS'(1);
						if (wake_left_q == RUN_BITS'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.reply_kind     = out_kind_q;
	assign rsp.target_id      = ID_W'(out_target_q);
	assign rsp.status         = out_status_q;
	assign rsp.exclusive_held = out_excl_q;
	assign rsp.requester_owns = out_owns_q;
	assign rsp.hold_count     = HOLD_W'(out_holds_q);
	assign rsp.last           = out_last_q;

endmodule

`default_nettype wire

/* design/rwl_checker.sv */
// ---------------------------------------------------------------------------
// rwl_checker
// port-level checks of the lock manager, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rwl_checker import rwl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                rsp_kind,
	input logic [ID_W-1:0]     rsp_target,
	input logic [STATUS_W-1:0] rsp_status,
	input logic                rsp_excl,
	input logic                rsp_owns,
	input logic [HOLD_W-1:0]   rsp_holds,
	input logic                rsp_last
);

	localparam int PAY_W = ID_W + STATUS_W + HOLD_W + 4;

	logic [PAY_W-1:0] rsp_payload;

	assign rsp_payload = {rsp_kind, rsp_target, rsp_status, rsp_excl, rsp_owns, rsp_holds,
		rsp_last};

	// a stalled result holds its payload
	`RWL_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

	// no new request while wake grants are still pending
	`RWL_ASSERT_IMP(a_no_req_mid_burst, clk, arst_n, rsp_valid && !rsp_last, !req_ready)

	// wake grants are always grants
	`RWL_ASSERT_IMP(a_wake_granted, clk, arst_n, rsp_valid && rsp_kind == KIND_WAKE, rsp_status == ST_GRANTED)

	// an exclusive wake is a single grant holding the lock once
	`RWL_ASSERT_IMP(a_excl_wake_single, clk, arst_n, rsp_valid && rsp_kind == KIND_WAKE && rsp_excl, rsp_holds == HOLD_W'(1) && rsp_last && rsp_owns)

	// ownership implies an exclusive holder
	`RWL_ASSERT_IMP(a_owns_excl, clk, arst_n, rsp_valid && rsp_owns, rsp_excl)

endmodule

bind reader_writer_lock_manager_top rwl_checker u_rwl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_kind   (rsp.reply_kind),
	.rsp_target (rsp.target_id),
	.rsp_status (rsp.status),
	.rsp_excl   (rsp.exclusive_held),
	.rsp_owns   (rsp.requester_owns),
	.rsp_holds  (rsp.hold_count),
	.rsp_last   (rsp.last)
);

`default_nettype wire

/* tb/rwl_grant_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rwl_grant_checker
// watches the request and result channels of the lock manager, keeps its
// own copy of the hold count, owner and waiter queue, works out the reply
// and wake grants of every accepted request and compares each accepted
// result with the oldest one still due
// ---------------------------------------------------------------------------
module rwl_grant_checker import rwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rwl_req_if   req,
	rwl_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   req_count,
	output int   wake_count,
	output int   full_count,
	output int   overflow_count,
	output int   refused_count,
	output int   rel_err_count
);

	localparam int DEPTH    = QUEUE_DEPTH_DEF;
	localparam int HOLD_MAX = (1 << COUNT_BITS_DEF) - 1;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   target;
		status_t           status;
		logic              excl;
		logic              owns;
		logic [HOLD_W-1:0] holds;
		logic              last;
	} grant_item_t;

	grant_item_t       replies_due [$];
	logic [HOLD_W-1:0] hold_cnt;
	logic              owner_vld;
	logic [ID_W-1:0]   owner;
	logic [ID_W:0]     waiters [DEPTH];
	int unsigned       head;
	int unsigned       tail;
	int unsigned       occupancy;
	int                seen_cnt;

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 50) begin
			$display("%0t mismatch: %s", $time, what);
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				seen_cnt, field, got, want));
		end
	endtask

	function automatic status_t park_waiter(input logic [ID_W-1:0] id, input logic excl);
		if (occupancy >= DEPTH) begin
			return ST_QUEUE_FULL;
		end
		waiters[tail] = {excl, id};
		tail = (tail + 1) % DEPTH;
		occupancy++;
		return ST_QUEUED;
	endfunction

	task automatic predict_grants(input func_t op, input logic [ID_W-1:0] id);
		status_t         st;
		logic [ID_W:0]   ent;
		logic [ID_W-1:0] woken [$];
		logic            req_owns;
		woken = {};
		req_owns = owner_vld && owner == id;
		case (op)
			FUNC_LOCK_SH: begin
				if (hold_cnt != 0 && owner_vld && !req_owns) begin
					st = park_waiter(id, 1'b0);
				end else if (hold_cnt >= HOLD_MAX) begin
					st = ST_OVERFLOW;
				end else begin
					hold_cnt++;
					st = ST_GRANTED;
				end
			end
			FUNC_LOCK_EX, FUNC_TRY_EX: begin
				if (hold_cnt != 0 && !req_owns) begin
					st = (op == FUNC_LOCK_EX) ? park_waiter(id, 1'b1) : ST_TRY_REFUSED;
				end else if (hold_cnt >= HOLD_MAX) begin
					st = ST_OVERFLOW;
				end else begin
					hold_cnt++;
					owner_vld = 1'b1;
					owner = id;
					st = ST_GRANTED;
				end
			end
			default: begin
				if (hold_cnt == 0) begin
					st = ST_REL_ERROR;
				end else begin
					st = ST_RELEASED;
					hold_cnt--;
					if (hold_cnt == 0 && occupancy == 0) begin
						owner_vld = 1'b0;
					end else if (hold_cnt == 0) begin
						// wake the head waiter and, if it is shared, the run of shared waiters behind it
						do begin
							ent = waiters[head];
							head = (head + 1) % DEPTH;
							occupancy--;
							hold_cnt++;
							owner_vld = ent[ID_W];
							owner = owner_vld ? ent[ID_W-1:0] : '0;
							woken.push_back(ent[ID_W-1:0]);
						end while (!owner_vld && occupancy != 0 && !waiters[head][ID_W]
							&& hold_cnt < HOLD_MAX && woken.size() < DEPTH);
					end
				end
			end
		endcase
		case (st)
			ST_QUEUE_FULL:  full_count++;
			ST_OVERFLOW:    overflow_count++;
			ST_TRY_REFUSED: refused_count++;
			ST_REL_ERROR:   rel_err_count++;
			default: ;
		endcase
		wake_count += woken.size();
		replies_due.push_back(grant_item_t'{KIND_REPLY, id, st, owner_vld,
			owner_vld && owner == id, hold_cnt, woken.size() == 0});
		foreach (woken[i]) begin
			replies_due.push_back(grant_item_t'{KIND_WAKE, woken[i], ST_GRANTED, owner_vld,
				owner_vld && owner == woken[i], hold_cnt, i == woken.size() - 1});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_item_t want;
		if (!arst_n) begin
			hold_cnt = '0;
			owner_vld = 1'b0;
			owner = '0;
			head = 0;
			tail = 0;
			occupancy = 0;
			replies_due.delete();
		end else begin
			if (req.valid && req.ready) begin
				req_count++;
				predict_grants(func_t'(req.func), req.requester_id);
			end
			if (rsp.valid && rsp.ready) begin
				seen_cnt++;
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing due", seen_cnt));
				end else begin
					want = replies_due.pop_front();
					check_field("reply_kind", rsp.reply_kind, want.kind);
					check_field("target_id", rsp.target_id, want.target);
					check_field("status", rsp.status, want.status);
					check_field("exclusive_held", rsp.exclusive_held, want.excl);
					check_field("requester_owns", rsp.requester_owns, want.owns);
					check_field("hold_count", rsp.hold_count, want.holds);
					check_field("last", rsp.last, want.last);
				end
			end
		end
		pending = replies_due.size();
	end

endmodule

/* tb/tb_reader_writer_lock_manager_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_reader_writer_lock_manager_top
// drives lock requests into the lock manager with random gaps and result
// stalls: a directed opening, one exclusive owner with a full waiter queue
// behind it, then random contention episodes and noise; the checker beside
// the block does the comparing
// ---------------------------------------------------------------------------
module tb_reader_writer_lock_manager_top;
	import rwl_pkg::*;

	localparam int TOTAL_ITEMS = 210;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_OFF    = 300;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   req_sent;
	int   rsp_taken;
	int   cycle_cnt;
	int   errors;
	int   pending;
	int   req_count;
	int   wake_count;
	int   full_count;
	int   overflow_count;
	int   refused_count;
	int   rel_err_count;

	rwl_req_if req_ch ();
	rwl_rsp_if rsp_ch ();

	reader_writer_lock_manager_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rwl_grant_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.errors         (errors),
		.pending        (pending),
		.req_count      (req_count),
		.wake_count     (wake_count),
		.full_count     (full_count),
		.overflow_count (overflow_count),
		.refused_count  (refused_count),
		.rel_err_count  (rel_err_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_lock(input func_t op, input logic [ID_W-1:0] id);
		int gap;
		if (req_sent % 40 == 0) begin
			calm = ($urandom_range(0, 3) == 0);
		end
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= op;
		req_ch.requester_id <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		req_sent++;
		@(negedge clk);
	endtask

	// result side
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			rsp_taken++;
			@(negedge clk);
			// long hold-off so the block backs up into the request side
			if (rsp_taken == 100) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
		end
	end

	// request side
	initial begin
		logic [ID_W-1:0] sat_id;
		logic [ID_W-1:0] writer;
		logic [ID_W-1:0] pool [4];
		int              relocks;
		int              k;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LOCK_SH;
		req_ch.requester_id = '0;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		send_lock(FUNC_UNLOCK, 8'h00);
		send_lock(FUNC_LOCK_SH, 8'h00);
		send_lock(FUNC_LOCK_SH, 8'hff);
		send_lock(FUNC_TRY_EX, 8'h5a);
		send_lock(FUNC_LOCK_EX, 8'ha5);
		send_lock(FUNC_LOCK_SH, 8'h33);
		send_lock(FUNC_LOCK_EX, 8'h00);
		repeat (3) send_lock(FUNC_UNLOCK, 8'h77);
		send_lock(FUNC_LOCK_EX, 8'ha5);
		send_lock(FUNC_TRY_EX, 8'ha5);
		send_lock(FUNC_LOCK_SH, 8'ha5);
		send_lock(FUNC_LOCK_SH, 8'h11);
		send_lock(FUNC_LOCK_SH, 8'h22);
		send_lock(FUNC_LOCK_EX, 8'h44);
		send_lock(FUNC_TRY_EX, 8'h11);
		repeat (4) send_lock(FUNC_UNLOCK, 8'hff);
		send_lock(FUNC_UNLOCK, 8'h00);
		send_lock(FUNC_UNLOCK, 8'h11);
		send_lock(FUNC_UNLOCK, 8'h22);
		send_lock(FUNC_UNLOCK, 8'h44);

		// one exclusive owner, then blocked requests until the waiter queue is full
		sat_id = ID_W'($urandom);
		send_lock(FUNC_LOCK_EX, sat_id);
		send_lock(FUNC_LOCK_SH, sat_id);
		send_lock(FUNC_TRY_EX, sat_id);
		repeat (17) begin
			send_lock($urandom_range(0, 1) ? FUNC_LOCK_SH : FUNC_LOCK_EX,
				sat_id ^ ID_W'($urandom_range(1, 255)));
		end
		send_lock(FUNC_TRY_EX, sat_id ^ ID_W'($urandom_range(1, 255)));
		repeat (20) send_lock(FUNC_UNLOCK, ID_W'($urandom));

		// contention episodes mixed with noise
		while (req_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 4) < 3) begin
				foreach (pool[i]) pool[i] = ID_W'($urandom);
				writer = pool[0];
				relocks = $urandom_range(0, 2);
				send_lock(FUNC_LOCK_EX, writer);
				repeat (relocks) send_lock(func_t'($urandom_range(0, 2)), writer);
				repeat ($urandom_range(1, 18)) begin
					k = $urandom_range(0, 9);
					send_lock(k < 6 ? FUNC_LOCK_SH : (k < 9 ? FUNC_LOCK_EX : FUNC_TRY_EX),
						pool[$urandom_range(0, 3)]);
				end
				repeat (relocks + 1 + $urandom_range(0, 6)) begin
					send_lock(FUNC_UNLOCK, pool[$urandom_range(0, 3)]);
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_lock(func_t'($urandom_range(0, 3)), ID_W'($urandom));
				end
			end
		end

		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d requests, %0d wake grants, %0d queue-full replies, %0d overflows",
			req_count, wake_count, full_count, overflow_count);
		$display("plus %0d refused tries, %0d releases at zero, and a %0d-cycle result stall",
			refused_count, rel_err_count, HOLD_OFF);
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
